[rtl/srb_pkg.sv]
// Shared types and constants for the sequence reorder buffer.
// Used by the core, the slot address unit's users and the port checker.
// No dependencies.
`default_nettype none

package srb_pkg;

    // Field widths of the segment transaction.
    localparam int SEQ_W = 16;
    localparam int TAG_W = 16;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_STALE    = 2'd1,
        ST_BEYOND   = 2'd2
    } t_status;

    // One entry of the pending store: occupancy flag and buffer tag.
    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } t_slot;

endpackage

`default_nettype wire

[rtl/srb_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Holds the pending slots of the reorder buffer. No dependencies.
`default_nettype none

module srb_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 32
) (
    input  wire                      i_clk,
    input  wire                      i_wr_en,
    input  wire [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  wire [WIDTH-1:0]          i_wr_data,
    input  wire                      i_rd_en,
    input  wire [$clog2(DEPTH)-1:0]  i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/srb_slot_addr.sv]
// Shared slot address unit: adds an offset to a queue's ring head modulo the
// window and forms the memory address of that slot. No dependencies.
`default_nettype none

module srb_slot_addr #(
    parameter int WINDOW     = 16,
    parameter int NUM_QUEUES = 2
) (
    input  wire  [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] i_queue,
    input  wire  [$clog2(WINDOW)-1:0]                                i_head,
    input  wire  [$clog2(WINDOW+1)-1:0]                              i_offset,
    output logic [$clog2(WINDOW)-1:0]                                o_pos,
    output logic [$clog2(NUM_QUEUES*WINDOW)-1:0]                     o_addr
);

    localparam int PW = $clog2(WINDOW);
    localparam int KW = $clog2(WINDOW + 1);
    localparam int AW = $clog2(NUM_QUEUES * WINDOW);

    logic [KW:0]   w_sum;
    logic [AW-1:0] w_base;

    // The sum stays below twice the window, so one compare and subtract wraps it.
    always_comb begin
        w_sum = (KW+1)'(i_head) + (KW+1)'(i_offset);
        if (w_sum >= (KW+1)'(WINDOW)) begin
            o_pos = PW'(w_sum - (KW+1)'(WINDOW));
        end else begin
            o_pos = PW'(w_sum);
        end
    end

    // Each queue owns a contiguous block of the window size.
    assign w_base = AW'(int'(i_queue) * WINDOW);
    assign o_addr = w_base + AW'(o_pos);

endmodule

`default_nettype wire

[rtl/sequence_reorder_buffer_core.sv]
// Per-queue segment resequencer: releases in-order runs, stores early arrivals, rejects the rest.
// An accepted arrival is classified, then stored, rejected or released; results are registered.
// A run of n released segments leaves at one per cycle, set by the slot memory read port,
// while the result channel is not stalled; no new input is taken until the run has been issued.
// After reset a clearing pass sweeps all NUM_QUEUES*WINDOW slots of the slot memory;
// no input is taken meanwhile. Depends on srb_pkg, srb_ram and srb_slot_addr.
`default_nettype none

module sequence_reorder_buffer_core
    import srb_pkg::*;
#(
    parameter int WINDOW     = 16,
    parameter int NUM_QUEUES = 2
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    // Arriving segment channel.
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire               i_queue_select,
    input  wire  [SEQ_W-1:0]  i_seq_number,
    input  wire  [TAG_W-1:0]  i_segment_tag,
    // Result channel.
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic              o_out_queue,
    output logic [SEQ_W-1:0]  o_out_seq_number,
    output logic [TAG_W-1:0]  o_out_tag,
    output logic [1:0]        o_status,
    output logic              o_last
);

    localparam int PW    = $clog2(WINDOW);
    localparam int KW    = $clog2(WINDOW + 1);
    localparam int DEPTH = NUM_QUEUES * WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int QIW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_CALC   = 7'b0000100,
        S_STORE  = 7'b0001000,
        S_REJECT = 7'b0010000,
        S_DRAIN  = 7'b0100000,
        S_FINAL  = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [SEQ_W-1:0] r_next [NUM_QUEUES];
    logic [SEQ_W-1:0] n_next [NUM_QUEUES];
    logic [PW-1:0]    r_head [NUM_QUEUES];
    logic [PW-1:0]    n_head [NUM_QUEUES];

    // Captured arrival.
    logic             r_queue, n_queue;
    logic [SEQ_W-1:0] r_seq, n_seq;
    logic [TAG_W-1:0] r_tag, n_tag;
    t_status          r_rej_status, n_rej_status;

    // Drain run: pending segment waiting for the next slot's lookup.
    logic [KW-1:0]    r_k, n_k;
    logic [SEQ_W-1:0] r_pend_seq, n_pend_seq;
    logic [TAG_W-1:0] r_pend_tag, n_pend_tag;
    logic [AW-1:0]    r_slot_addr, n_slot_addr;

    // Output register.
    logic             r_out_valid, n_out_valid;
    logic             r_out_queue, n_out_queue;
    logic [SEQ_W-1:0] r_out_seq, n_out_seq;
    logic [TAG_W-1:0] r_out_tag, n_out_tag;
    t_status          r_out_status, n_out_status;
    logic             r_out_last, n_out_last;

    // Memory and address unit signals.
    logic             w_wr_en, w_rd_en;
    logic [AW-1:0]    w_wr_addr;
    t_slot            w_wr_data, w_rd_data;
    logic [QIW-1:0]   w_q;
    logic [KW-1:0]    w_offset;
    logic [PW-1:0]    w_pos;
    logic [AW-1:0]    w_addr;
    logic [SEQ_W-1:0] w_dist;
    logic             w_q_bad;
    logic             w_out_free;
    logic             w_accept;

    assign w_q        = QIW'(r_queue);
    assign w_q_bad    = (int'(r_queue) >= NUM_QUEUES);
    assign w_dist     = r_seq - r_next[w_q];
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    // Offset fed to the shared address unit, chosen by the sequencer step.
    always_comb begin
        priority if (r_state == S_CALC) begin
            w_offset = (w_dist == '0) ? KW'(1) : KW'(w_dist[PW-1:0]);
        end else if (r_state == S_DRAIN && w_rd_data.valid) begin
            w_offset = r_k + KW'(1);
        end else begin
            w_offset = r_k;
        end
    end

    srb_slot_addr #(
        .WINDOW     (WINDOW),
        .NUM_QUEUES (NUM_QUEUES)
    ) u_addr (
        .i_queue  (w_q),
        .i_head   (r_head[w_q]),
        .i_offset (w_offset),
        .o_pos    (w_pos),
        .o_addr   (w_addr)
    );

    srb_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_data)
    );

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_next       = r_next;
        n_head       = r_head;
        n_queue      = r_queue;
        n_seq        = r_seq;
        n_tag        = r_tag;
        n_rej_status = r_rej_status;
        n_k          = r_k;
        n_pend_seq   = r_pend_seq;
        n_pend_tag   = r_pend_tag;
        n_slot_addr  = r_slot_addr;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_queue  = r_out_queue;
        n_out_seq    = r_out_seq;
        n_out_tag    = r_out_tag;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_slot_addr;
        w_wr_data    = '{valid: 1'b0, tag: r_tag};
        w_rd_en      = 1'b0;

        unique case (r_state)
            // Sweep the slot memory empty after reset.
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (w_accept) begin
                    n_queue = i_queue_select;
                    n_seq   = i_seq_number;
                    n_tag   = i_segment_tag;
                    n_state = S_CALC;
                end
            end

            // Classify the arrival by its modular distance to the expected number.
            S_CALC: begin
                priority if (w_q_bad) begin
                    n_rej_status = ST_BEYOND;
                    n_state      = S_REJECT;
                end else if (w_dist == '0) begin
                    n_pend_seq  = r_seq;
                    n_pend_tag  = r_tag;
                    n_k         = KW'(1);
                    w_rd_en     = 1'b1;
                    n_slot_addr = w_addr;
                    n_state     = S_DRAIN;
                end else if (w_dist < SEQ_W'(WINDOW)) begin
                    w_rd_en     = 1'b1;
                    n_slot_addr = w_addr;
                    n_state     = S_STORE;
                end else if (w_dist[SEQ_W-1]) begin
                    n_rej_status = ST_STALE;
                    n_state      = S_REJECT;
                end else begin
                    n_rej_status = ST_BEYOND;
                    n_state      = S_REJECT;
                end
            end

            // Store an early arrival unless its slot is already taken.
            S_STORE: begin
                if (w_rd_data.valid) begin
                    n_rej_status = ST_STALE;
                    n_state      = S_REJECT;
                end else begin
                    w_wr_en   = 1'b1;
                    w_wr_data = '{valid: 1'b1, tag: r_tag};
                    n_state   = S_IDLE;
                end
            end

            S_REJECT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_queue  = r_queue;
                    n_out_seq    = r_seq;
                    n_out_tag    = r_tag;
                    n_out_status = r_rej_status;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            // Emit the pending segment once the next slot's occupancy is known.
            S_DRAIN: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_queue  = r_queue;
                    n_out_seq    = r_pend_seq;
                    n_out_tag    = r_pend_tag;
                    n_out_status = ST_RELEASED;
                    n_out_last   = !w_rd_data.valid;
                    if (w_rd_data.valid) begin
                        w_wr_en    = 1'b1;
                        n_pend_seq = r_pend_seq + SEQ_W'(1);
                        n_pend_tag = w_rd_data.tag;
                        n_k        = r_k + KW'(1);
                        if (r_k == KW'(WINDOW - 1)) begin
                            n_state = S_FINAL;
                        end else begin
                            w_rd_en     = 1'b1;
                            n_slot_addr = w_addr;
                        end
                    end else begin
                        n_next[w_q] = r_next[w_q] + SEQ_W'(r_k);
                        n_head[w_q] = w_pos;
                        n_state     = S_IDLE;
                    end
                end
            end

            // The whole window was released; emit its final segment.
            S_FINAL: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_queue  = r_queue;
                    n_out_seq    = r_pend_seq;
                    n_out_tag    = r_pend_tag;
                    n_out_status = ST_RELEASED;
                    n_out_last   = 1'b1;
                    n_next[w_q]  = r_next[w_q] + SEQ_W'(r_k);
                    n_head[w_q]  = w_pos;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_next[i] <= '0;
                r_head[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_next      <= n_next;
            r_head      <= n_head;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_queue      <= n_queue;
        r_seq        <= n_seq;
        r_tag        <= n_tag;
        r_rej_status <= n_rej_status;
        r_k          <= n_k;
        r_pend_seq   <= n_pend_seq;
        r_pend_tag   <= n_pend_tag;
        r_slot_addr  <= n_slot_addr;
        r_out_queue  <= n_out_queue;
        r_out_seq    <= n_out_seq;
        r_out_tag    <= n_out_tag;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_out_queue      = r_out_queue;
    assign o_out_seq_number = r_out_seq;
    assign o_out_tag        = r_out_tag;
    assign o_status         = r_out_status;
    assign o_last           = r_out_last;

endmodule

`default_nettype wire

[rtl/srb_checker.sv]
// Port-level checks for the sequence reorder buffer core, bound to its top.
// Depends on srb_pkg for the status codes.
`default_nettype none

module srb_checker
    import srb_pkg::*;
(
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_in_valid,
    input wire              o_in_stall,
    input wire              i_queue_select,
    input wire  [SEQ_W-1:0] i_seq_number,
    input wire  [TAG_W-1:0] i_segment_tag,
    input wire              o_out_valid,
    input wire              i_out_stall,
    input wire              o_out_queue,
    input wire  [SEQ_W-1:0] o_out_seq_number,
    input wire  [TAG_W-1:0] o_out_tag,
    input wire  [1:0]       o_status,
    input wire              o_last
);

    // The clearing pass keeps the input side stalled right after reset.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during the clearing pass");

    // One transaction at a time: an accepted arrival makes the block busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted transaction");

    // A rejected result is always the only result of its arrival.
    a_reject_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_RELEASED) |-> o_last)
        else $error("rejected result without last");

    // While a released run is still going, no new arrival may be taken.
    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_status == ST_RELEASED && !o_last)
            |-> o_in_stall)
        else $error("input ready in the middle of a released run");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_seq_number) && $stable(o_out_tag)
             && $stable(o_status) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind sequence_reorder_buffer_core srb_checker u_srb_checker (.*);

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for sequence_reorder_buffer_core: directed and random segment traffic.
// Predicts released and rejected segments per queue and checks every result transaction.
// Depends on srb_pkg and the core RTL.

module tb_top;
    import srb_pkg::*;

    localparam int WINDOW      = 16;
    localparam int NUM_QUEUES  = 2;
    localparam int DRAIN_WAIT  = 40;      // covers one run of WINDOW results plus overhead
    localparam int DRAIN_LIMIT = 200000;

    // One result transaction as the core presents it.
    typedef struct packed {
        logic             queue;
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] tag;
        t_status          status;
        logic             last;
    } t_segment_result;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             in_valid     = 1'b0;
    logic             in_stall;
    logic             queue_select = 1'b0;
    logic [SEQ_W-1:0] seq_number   = '0;
    logic [TAG_W-1:0] segment_tag  = '0;
    logic             out_valid;
    logic             out_stall    = 1'b0;
    logic             out_queue;
    logic [SEQ_W-1:0] out_seq;
    logic [TAG_W-1:0] out_tag;
    logic [1:0]       out_status;
    logic             out_last;

    // Predicted state of the resequencer.
    logic [SEQ_W-1:0] expected_seq [NUM_QUEUES];
    logic             pending_valid [NUM_QUEUES][WINDOW];
    logic [TAG_W-1:0] pending_tag [NUM_QUEUES][WINDOW];
    t_segment_result  expected_segments [$];

    int mismatches    = 0;
    int items_sent    = 0;
    int rx_hold_left  = 0;
    int rx_stall_left = 0;
    bit rx_idle_on    = 1'b1;
    bit tx_idle_on    = 1'b1;

    sequence_reorder_buffer_core #(
        .WINDOW     (WINDOW),
        .NUM_QUEUES (NUM_QUEUES)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_queue_select   (queue_select),
        .i_seq_number     (seq_number),
        .i_segment_tag    (segment_tag),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_out_queue      (out_queue),
        .o_out_seq_number (out_seq),
        .o_out_tag        (out_tag),
        .o_status         (out_status),
        .o_last           (out_last)
    );

    always #1 clk = ~clk;

    // Give up on a hung run.
    initial begin
        #2_000_000;
        $display("** sequence_reorder_buffer_core: FAILED **");
        $finish;
    end

    function automatic t_segment_result segment_result(input logic q,
                                                       input logic [SEQ_W-1:0] seq,
                                                       input logic [TAG_W-1:0] tag,
                                                       input t_status status,
                                                       input logic last);
        t_segment_result r;
        r.queue  = q;
        r.seq    = seq;
        r.tag    = tag;
        r.status = status;
        r.last   = last;
        return r;
    endfunction

    // Append one predicted result at the tail of the expected list.
    function automatic void add_expected(input t_segment_result r);
        expected_segments.insert(expected_segments.size(), r);
    endfunction

    // Apply one accepted arrival to the predicted state and queue its results.
    task automatic predict_arrival(input logic q, input logic [SEQ_W-1:0] seq,
                                   input logic [TAG_W-1:0] tag);
        logic [SEQ_W-1:0] delta;
        int run;
        delta = seq - expected_seq[q];
        if (delta == 0) begin
            run = 1;
            while (run < WINDOW && pending_valid[q][run])
                run++;
            add_expected(segment_result(q, seq, tag, ST_RELEASED, run == 1));
            for (int k = 1; k < run; k++)
                add_expected(segment_result(q, seq + k[SEQ_W-1:0],
                    pending_tag[q][k], ST_RELEASED, k + 1 == run));
            // Slide the window past the released run.
            for (int j = 0; j < WINDOW; j++) begin
                if (j + run < WINDOW) begin
                    pending_valid[q][j] = pending_valid[q][j + run];
                    pending_tag[q][j]   = pending_tag[q][j + run];
                end else begin
                    pending_valid[q][j] = 1'b0;
                end
            end
            expected_seq[q] = expected_seq[q] + run[SEQ_W-1:0];
        end else if (delta < WINDOW) begin
            if (pending_valid[q][delta]) begin
                add_expected(segment_result(q, seq, tag, ST_STALE, 1'b1));
            end else begin
                pending_valid[q][delta] = 1'b1;
                pending_tag[q][delta]   = tag;
            end
        end else if (delta >= 16'h8000) begin
            add_expected(segment_result(q, seq, tag, ST_STALE, 1'b1));
        end else begin
            add_expected(segment_result(q, seq, tag, ST_BEYOND, 1'b1));
        end
    endtask

    // Offer one segment and hold it until the core takes it.
    task automatic send_segment(input logic q, input logic [SEQ_W-1:0] seq,
                                input logic [TAG_W-1:0] tag);
        @(negedge clk);
        in_valid     <= 1'b1;
        queue_select <= q;
        seq_number   <= seq;
        segment_tag  <= tag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_arrival(q, seq, tag);
        items_sent++;
    endtask

    // Sender idle time: mostly none, sometimes short, rarely long.
    task automatic sender_gap();
        int r;
        int n;
        r = $urandom_range(99);
        n = 0;
        if (!tx_idle_on || r < 65)
            n = 0;
        else if (r < 93)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 24);
        if (n > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Stop sending until every predicted result has arrived and the core is quiet.
    task automatic wait_for_drain();
        int guard;
        guard = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_segments.size() > 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Send k consecutive numbers from the queue's expected one in shuffled order.
    task automatic send_shuffled_run(input logic q, input int k);
        logic [SEQ_W-1:0] nums [$];
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] swap;
        int j;
        base = expected_seq[q];
        for (int i = 0; i < k; i++)
            nums.insert(nums.size(), base + i[SEQ_W-1:0]);
        for (int i = k - 1; i > 0; i--) begin
            j       = $urandom_range(i);
            swap    = nums[i];
            nums[i] = nums[j];
            nums[j] = swap;
        end
        foreach (nums[i]) begin
            send_segment(q, nums[i], TAG_W'($urandom));
            sender_gap();
        end
    endtask

    // Both queues release at once; tags at both extremes.
    task automatic test_in_order();
        send_segment(1'b0, 16'd0, 16'hFFFF);
        send_segment(1'b1, 16'd0, 16'h0000);
    endtask

    // Fill every slot of queue 0, hit a pending duplicate, then drain the full run.
    task automatic test_full_window();
        for (int s = WINDOW; s >= 2; s--)
            send_segment(1'b0, s[SEQ_W-1:0], TAG_W'($urandom));
        send_segment(1'b0, WINDOW[SEQ_W-1:0], 16'hFFFF);
        send_segment(1'b0, 16'd1, 16'h0000);
    endtask

    // Window edges, the stale boundary and the wrap behind the expected number.
    task automatic test_rejects();
        send_segment(1'b1, 16'd1 + WINDOW[SEQ_W-1:0], 16'hFFFF);
        send_segment(1'b1, 16'd1 + 16'd32767, 16'h0000);
        send_segment(1'b1, 16'd1 + 16'd32768, 16'hA5A5);
        send_segment(1'b1, 16'd0, 16'h5A5A);
        send_segment(1'b0, 16'hFFFF, 16'hFFFF);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_receiver_hold();
        tx_idle_on   = 1'b0;
        rx_hold_left = 300;
        for (int i = 0; i < 4; i++)
            send_shuffled_run(i[0], 8);
        tx_idle_on = 1'b1;
    endtask

    // Mostly shuffled in-order runs, plus stores, duplicates and rejects.
    task automatic test_random_traffic(input int target);
        int   r;
        logic q;
        while (items_sent < target) begin
            r = $urandom_range(99);
            q = 1'($urandom_range(1));
            if (r < 55) begin
                send_shuffled_run(q, ($urandom_range(5) == 0) ? $urandom_range(7, WINDOW)
                                                              : $urandom_range(1, 6));
            end else if (r < 70) begin
                send_segment(q, expected_seq[q] + SEQ_W'($urandom_range(1, WINDOW - 1)),
                             TAG_W'($urandom));
            end else if (r < 80) begin
                send_segment(q, expected_seq[q] - SEQ_W'($urandom_range(1, 32768)),
                             TAG_W'($urandom));
            end else if (r < 90) begin
                send_segment(q, expected_seq[q] + SEQ_W'($urandom_range(WINDOW, 32767)),
                             TAG_W'($urandom));
            end else begin
                send_segment(q, SEQ_W'($urandom), TAG_W'($urandom));
            end
            sender_gap();
        end
    endtask

    // Receiver stall pattern: random bursts, or one long hold when requested.
    always @(negedge clk) begin
        if (rx_hold_left > 0) begin
            out_stall <= 1'b1;
            rx_hold_left--;
        end else if (rx_stall_left > 0) begin
            out_stall <= 1'b1;
            rx_stall_left--;
        end else if (rx_idle_on && $urandom_range(99) < 30) begin
            out_stall     <= 1'b1;
            rx_stall_left = ($urandom_range(9) == 0) ? $urandom_range(7, 23)
                                                     : $urandom_range(0, 2);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Compare each result transaction with the oldest prediction.
    always @(posedge clk) begin
        t_segment_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_segments.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result q=%0d seq=%0d tag=%0d status=%0d last=%0d",
                             $time, out_queue, out_seq, out_tag, out_status, out_last);
            end else begin
                want = expected_segments[0];
                expected_segments.delete(0);
                if (out_queue !== want.queue || out_seq !== want.seq || out_tag !== want.tag ||
                    out_status !== want.status || out_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result mismatch", $time);
                        $display("  expected q=%0d seq=%0d tag=%0d status=%0d last=%0d",
                                 want.queue, want.seq, want.tag, want.status, want.last);
                        $display("  actual   q=%0d seq=%0d tag=%0d status=%0d last=%0d",
                                 out_queue, out_seq, out_tag, out_status, out_last);
                    end
                end
            end
        end
    end

    // Reset, then the tests in turn.
    initial begin
        for (int q = 0; q < NUM_QUEUES; q++) begin
            expected_seq[q] = '0;
            for (int s = 0; s < WINDOW; s++) begin
                pending_valid[q][s] = 1'b0;
                pending_tag[q][s]   = '0;
            end
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_in_order();
        test_full_window();
        test_rejects();
        wait_for_drain();
        test_receiver_hold();
        wait_for_drain();

        // Random phases; one stretch runs with no idling on either side.
        for (int phase = 0; phase < 6; phase++) begin
            tx_idle_on = (phase != 2);
            rx_idle_on = (phase != 2);
            test_random_traffic(items_sent + 66);
            if (phase % 2 == 1)
                wait_for_drain();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        wait_for_drain();

        if (expected_segments.size() > 0) begin
            $display("%0d expected results never arrived", expected_segments.size());
            mismatches += expected_segments.size();
        end
        if (mismatches == 0)
            $display("** sequence_reorder_buffer_core: PASSED **");
        else
            $display("** sequence_reorder_buffer_core: FAILED **");
        $finish;
    end

endmodule
